// ===== sv/d2p_pkg.sv =====
// Shared types and constants for the disparity-to-point reprojection unit.
// No dependencies; used by the interfaces, the top level and the checker.
package d2p_pkg;

    localparam int DISP_BITS  = 16;
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;
    localparam int DATA_BITS  = 32;
    localparam int IDX_BITS   = 4;

    // W and numerators: signed, one bit of headroom over the widest product
    localparam int NUM_BITS = DATA_BITS + DISP_BITS + 2;
    localparam int MAG_BITS = NUM_BITS - 1;
    localparam int Q_BITS   = DATA_BITS;
    localparam int LANES    = 3;

    typedef enum logic [IDX_BITS-1:0] {
        REG_X_GAIN    = 4'd0,
        REG_X_OFFSET  = 4'd1,
        REG_Y_GAIN    = 4'd2,
        REG_Y_OFFSET  = 4'd3,
        REG_DEPTH_NUM = 4'd4,
        REG_DISP_GAIN = 4'd5,
        REG_DISP_OFF  = 4'd6,
        REG_BAD_FILL  = 4'd7
    } t_reg_idx;

    // One division lane: partial remainder, dividend bits feeding in / quotient out
    typedef struct packed {
        logic [MAG_BITS-1:0] rem;
        logic [Q_BITS-1:0]   dq;
        logic                ovf;
        logic                neg;
    } t_lane;

    function automatic logic [MAG_BITS-1:0] f_abs(input logic signed [NUM_BITS-1:0] v);
        logic [NUM_BITS-1:0] t;
        t = v[NUM_BITS-1] ? (~v + NUM_BITS'(1)) : v;
        return t[MAG_BITS-1:0];
    endfunction

endpackage

// ===== sv/d2p_if.sv =====
// Handshake interfaces for pixels in, points out and register writes.
// Depends on d2p_pkg.
interface d2p_pix_if;
    logic                           valid;
    logic                           ready;
    logic [d2p_pkg::DISP_BITS-1:0]  disparity;
    logic [d2p_pkg::COORD_BITS-1:0] column;
    logic [d2p_pkg::COORD_BITS-1:0] row;
    modport source (output valid, disparity, column, row, input ready);
    modport sink   (input valid, disparity, column, row, output ready);
endinterface

interface d2p_pnt_if;
    logic                                valid;
    logic                                ready;
    logic signed [d2p_pkg::DATA_BITS-1:0] x_coord;
    logic signed [d2p_pkg::DATA_BITS-1:0] y_coord;
    logic signed [d2p_pkg::DATA_BITS-1:0] z_coord;
    logic                                point_bad;
    modport source (output valid, x_coord, y_coord, z_coord, point_bad, input ready);
    modport sink   (input valid, x_coord, y_coord, z_coord, point_bad, output ready);
endinterface

interface d2p_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [d2p_pkg::IDX_BITS-1:0]  index;
    logic [d2p_pkg::DATA_BITS-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/disparity_to_point_reprojection_unit.sv =====
// Disparity-to-point reprojection, top level: multiply, sum, 32-step divider pipeline.
// Depends on d2p_pkg and the interfaces in d2p_if.sv.
//
// Takes one pixel per clock while the output is not stalled and returns one signed
// Q16.16 point (X, Y, Z) per pixel. The pipeline is three parallel restoring
// dividers, one quotient bit per stage over 32 stages, behind a multiply stage,
// an add/abs stage and a range-check stage, with one output register after them.
// The whole pipeline advances whenever the output register is empty or being
// taken, so throughput is one point per clock. A zero W or an out-of-range
// quotient yields bad_fill in all three coordinates with point_bad set. The user
// must write registers through i_cfg only while no pixel is in flight; the block
// itself does not enforce this. Indexes beyond the list are ignored.
module disparity_to_point_reprojection_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    d2p_pix_if.sink    i_pix,
    d2p_pnt_if.source  o_pnt,
    d2p_cfg_if.sink    i_cfg
);
    localparam int STEPS = d2p_pkg::Q_BITS;
    localparam int MB    = d2p_pkg::MAG_BITS;
    localparam int NB    = d2p_pkg::NUM_BITS;
    localparam int DB    = d2p_pkg::DATA_BITS;
    localparam int FB    = d2p_pkg::FRAC_BITS;
    localparam int Q_BITS_M1 = d2p_pkg::Q_BITS - 1;

    // Configuration registers
    logic [DB-1:0] r_xg, r_xo, r_yg, r_yo, r_dn, r_dg, r_do, r_bad;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xg  <= DB'(65536);
            r_xo  <= '0;
            r_yg  <= DB'(65536);
            r_yo  <= '0;
            r_dn  <= DB'(65536);
            r_dg  <= DB'(65536);
            r_do  <= '0;
            r_bad <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                d2p_pkg::REG_X_GAIN:    r_xg  <= i_cfg.data;
                d2p_pkg::REG_X_OFFSET:  r_xo  <= i_cfg.data;
                d2p_pkg::REG_Y_GAIN:    r_yg  <= i_cfg.data;
                d2p_pkg::REG_Y_OFFSET:  r_yo  <= i_cfg.data;
                d2p_pkg::REG_DEPTH_NUM: r_dn  <= i_cfg.data;
                d2p_pkg::REG_DISP_GAIN: r_dg  <= i_cfg.data;
                d2p_pkg::REG_DISP_OFF:  r_do  <= i_cfg.data;
                d2p_pkg::REG_BAD_FILL:  r_bad <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Global advance: the pipe moves when the output slot is free or being taken
    logic w_en;
    assign w_en        = !o_pnt.valid || o_pnt.ready;
    assign i_pix.ready = w_en;

    // Stage 1: products
    logic              r1_v;
    logic signed [NB-1:0] r1_px, r1_py, r1_pw;
    logic signed [NB-1:0] w_px, w_py, w_pw;

    assign w_px = $signed(r_xg) * $signed({1'b0, i_pix.column});
    assign w_py = $signed(r_yg) * $signed({1'b0, i_pix.row});
    assign w_pw = $signed(r_dg) * $signed({1'b0, i_pix.disparity});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (w_en) r1_v <= i_pix.valid;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_px <= w_px;
            r1_py <= w_py;
            r1_pw <= w_pw;
        end
    end

    // Stage 2: offsets, magnitudes and result signs
    logic              r2_v;
    logic [MB-1:0]     r2_an [d2p_pkg::LANES];
    logic              r2_ng [d2p_pkg::LANES];
    logic [MB-1:0]     r2_aw;
    logic signed [NB-1:0] w_nx, w_ny, w_nz, w_w;

    assign w_nx = r1_px + NB'($signed(r_xo));
    assign w_ny = r1_py + NB'($signed(r_yo));
    assign w_nz = NB'($signed(r_dn));
    assign w_w  = r1_pw + NB'($signed(r_do));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (w_en) r2_v <= r1_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_an[0] <= d2p_pkg::f_abs(w_nx);
            r2_an[1] <= d2p_pkg::f_abs(w_ny);
            r2_an[2] <= d2p_pkg::f_abs(w_nz);
            r2_ng[0] <= w_nx[NB-1] ^ w_w[NB-1];
            r2_ng[1] <= w_ny[NB-1] ^ w_w[NB-1];
            r2_ng[2] <= w_nz[NB-1] ^ w_w[NB-1];
            r2_aw    <= d2p_pkg::f_abs(w_w);
        end
    end

    // Divider stages: entry 0 is the range check and setup, 1..STEPS one bit each
    logic            r_dv [STEPS+1];
    logic [MB-1:0]   r_aw [STEPS];
    d2p_pkg::t_lane  r_ln [STEPS+1][d2p_pkg::LANES];
    d2p_pkg::t_lane  n_ln [STEPS+1][d2p_pkg::LANES];

    always_comb begin
        logic [MB-1:0] init_rem;
        logic [MB:0]   trial;
        for (int l = 0; l < d2p_pkg::LANES; l++) begin
            // dividend is |n| << FRAC_BITS; the quotient fits 32 bits iff |n|>>FB < |W|
            init_rem       = {FB'(0), r2_an[l][MB-1:FB]};
            n_ln[0][l].rem = init_rem;
            n_ln[0][l].dq  = {r2_an[l][FB-1:0], FB'(0)};
            n_ln[0][l].ovf = (init_rem >= r2_aw);
            n_ln[0][l].neg = r2_ng[l];
        end
        for (int k = 1; k <= STEPS; k++) begin
            for (int l = 0; l < d2p_pkg::LANES; l++) begin
                trial = {r_ln[k-1][l].rem, r_ln[k-1][l].dq[Q_BITS_M1]};
                n_ln[k][l].ovf = r_ln[k-1][l].ovf;
                n_ln[k][l].neg = r_ln[k-1][l].neg;
                if (trial >= {1'b0, r_aw[k-1]}) begin
                    n_ln[k][l].rem = MB'(trial - {1'b0, r_aw[k-1]});
                    n_ln[k][l].dq  = {r_ln[k-1][l].dq[Q_BITS_M1-1:0], 1'b1};
                end else begin
                    n_ln[k][l].rem = trial[MB-1:0];
                    n_ln[k][l].dq  = {r_ln[k-1][l].dq[Q_BITS_M1-1:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= STEPS; k++) r_dv[k] <= 1'b0;
        end else if (w_en) begin
            r_dv[0] <= r2_v;
            for (int k = 1; k <= STEPS; k++) r_dv[k] <= r_dv[k-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_aw[0] <= r2_aw;
            for (int k = 1; k < STEPS; k++) r_aw[k] <= r_aw[k-1];
            for (int k = 0; k <= STEPS; k++) begin
                for (int l = 0; l < d2p_pkg::LANES; l++) r_ln[k][l] <= n_ln[k][l];
            end
        end
    end

    // Output stage: signed range check, negate, fill on bad points
    logic          r_ov;
    logic [DB-1:0] r_x, r_y, r_z;
    logic          r_bd;
    logic [DB-1:0] w_c [d2p_pkg::LANES];
    logic          w_bad;

    always_comb begin
        logic [DB-1:0] q;
        w_bad = 1'b0;
        for (int l = 0; l < d2p_pkg::LANES; l++) begin
            q = r_ln[STEPS][l].dq;
            if (r_ln[STEPS][l].ovf) w_bad = 1'b1;
            if (r_ln[STEPS][l].neg) begin
                if (q > {1'b1, (DB-1)'(0)}) w_bad = 1'b1;
                w_c[l] = ~q + DB'(1);
            end else begin
                if (q[DB-1]) w_bad = 1'b1;
                w_c[l] = q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (w_en) r_ov <= r_dv[STEPS];
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bd <= w_bad;
            r_x  <= w_bad ? r_bad : w_c[0];
            r_y  <= w_bad ? r_bad : w_c[1];
            r_z  <= w_bad ? r_bad : w_c[2];
        end
    end

    assign o_pnt.valid     = r_ov;
    assign o_pnt.x_coord   = r_x;
    assign o_pnt.y_coord   = r_y;
    assign o_pnt.z_coord   = r_z;
    assign o_pnt.point_bad = r_bd;

endmodule

// ===== sv/d2p_checker.sv =====
// Port-level checks for the reprojection unit, bound to the top level.
// Depends on d2p_pkg and the top level's interface ports.
module d2p_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [d2p_pkg::DATA_BITS-1:0] i_x,
    input logic [d2p_pkg::DATA_BITS-1:0] i_y,
    input logic [d2p_pkg::DATA_BITS-1:0] i_z,
    input logic                        i_bad
);
    // a stalled point stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("point dropped while stalled");

    // bad points carry the same value in all three coordinates
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_bad |-> (i_x == i_y) && (i_y == i_z))
        else $error("bad point with differing coordinates");

    // nothing comes out right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // an empty output slot never blocks the input
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

endmodule

bind disparity_to_point_reprojection_unit d2p_checker u_d2p_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pnt.valid),
    .i_out_ready (o_pnt.ready),
    .i_x         (o_pnt.x_coord),
    .i_y         (o_pnt.y_coord),
    .i_z         (o_pnt.z_coord),
    .i_bad       (o_pnt.point_bad)
);
